// ===== hw/rtl/scc_pkg.sv =====
// shared constants and types for the sphere collision constraint pipeline
// no dependencies
package scc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EPS = (2 ** FRAC_BITS + 500000) / 1000000;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 32;
  localparam int NUM_W = 56;

  typedef struct packed {
    logic        valid;
    logic [2:0]  neg;
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
    logic [31:0] rs;
    logic [23:0] w0;
    logic [23:0] w1;
    logic [24:0] ws;
    logic        ovf;
  } side_t;

endpackage

// ===== hw/rtl/sphere_collision_constraint_top.sv =====
// Sphere collision constraint for one particle pair per transaction.
// Request channel: req_valid / req_stall with positions, radii and
// inverse masses. Response channel: rsp_valid / rsp_stall with collided,
// the two position corrections, the contact normal and the depth.
// One transaction enters every cycle unless the pipeline holds; the
// response passes the front stages, the 32-stage square root and the
// 32-stage dividers that form the normal and the mass shares.
// All stages advance together: while rsp_valid is high and rsp_stall is
// high the pipeline holds and req_stall is raised, nothing is lost or
// repeated. Reset clears every stage valid bit; no clearing pass is
// needed. Pairs without overlap, or with both inverse masses zero,
// give an all-zero response.
// depends on scc_pkg, scc_front, scc_sqrt, scc_div
module sphere_collision_constraint_top import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic signed [31:0] pos0_x,
  input  logic signed [31:0] pos0_y,
  input  logic signed [31:0] pos0_z,
  input  logic signed [31:0] pos1_x,
  input  logic signed [31:0] pos1_y,
  input  logic signed [31:0] pos1_z,
  input  logic [30:0]        radius0,
  input  logic [30:0]        radius1,
  input  logic [23:0]        weight0,
  input  logic [23:0]        weight1,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               collided,
  output logic signed [31:0] shift0_x,
  output logic signed [31:0] shift0_y,
  output logic signed [31:0] shift0_z,
  output logic signed [31:0] shift1_x,
  output logic signed [31:0] shift1_y,
  output logic signed [31:0] shift1_z,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic [31:0]        depth
);

  typedef struct packed {
    logic        valid;
    logic        coll;
    logic        zd;
    logic [2:0]  neg;
    logic [31:0] depth;
  } tail_t;

  function automatic logic [31:0] sat32(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    if (neg) begin
      m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
      return 32'(64'(0) - m);
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  logic        en;
  side_t       side_c, side_s;
  logic [63:0] sum_c;
  logic [31:0] root_s;

  // compare stage
  side_t       sd;
  logic        coll_d, zd_d;
  logic [31:0] depth_d, root_d;

  tail_t       tail [DIV_STEPS+1];
  logic [31:0] share0, share1;
  logic [31:0] nm [3];

  // product stage
  tail_t       tf;
  logic [63:0] pf0 [3];
  logic [63:0] pf1 [3];
  logic [31:0] nf  [3];

  logic [63:0] s0 [3];
  logic [63:0] s1 [3];
  logic [31:0] nv [3];
  logic        live;

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  scc_front u_front (
    .clk, .rst, .en, .in_valid(req_valid),
    .pos0_x, .pos0_y, .pos0_z, .pos1_x, .pos1_y, .pos1_z,
    .radius0, .radius1, .weight0, .weight1,
    .side(side_c), .sum(sum_c)
  );

  scc_sqrt u_sqrt (
    .clk, .rst, .en, .side_in(side_c), .num_in(sum_c),
    .side_out(side_s), .root(root_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sd.valid <= 1'b0;
    end else if (en) begin
      sd      <= side_s;
      root_d  <= root_s;
      coll_d  <= side_s.ws != '0 && !side_s.ovf &&
                 ({1'b0, root_s} + 33'(EPS) < {1'b0, side_s.rs});
      depth_d <= side_s.rs - root_s;
      zd_d    <= root_s == '0;
    end
  end

  scc_div u_div_s0 (
    .clk, .en, .num(NUM_W'(depth_d) * NUM_W'(sd.w0)), .den(32'(sd.ws)), .quo(share0)
  );
  scc_div u_div_s1 (
    .clk, .en, .num(NUM_W'(depth_d) * NUM_W'(sd.w1)), .den(32'(sd.ws)), .quo(share1)
  );
  scc_div u_div_nx (.clk, .en, .num(NUM_W'(sd.mag_x) << FRAC_BITS), .den(root_d), .quo(nm[0]));
  scc_div u_div_ny (.clk, .en, .num(NUM_W'(sd.mag_y) << FRAC_BITS), .den(root_d), .quo(nm[1]));
  scc_div u_div_nz (.clk, .en, .num(NUM_W'(sd.mag_z) << FRAC_BITS), .den(root_d), .quo(nm[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) tail[k].valid <= 1'b0;
      tf.valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      tail[0].valid <= sd.valid;
      tail[0].coll  <= coll_d;
      tail[0].zd    <= zd_d;
      tail[0].neg   <= sd.neg;
      tail[0].depth <= depth_d;
      for (int k = 0; k < DIV_STEPS; k++) tail[k+1] <= tail[k];
      tf <= tail[DIV_STEPS];
      for (int i = 0; i < 3; i++) begin
        pf0[i] <= share0 * nm[i];
        pf1[i] <= share1 * nm[i];
        nf[i]  <= nm[i];
      end
      rsp_valid <= tf.valid;
      collided  <= tf.coll;
      depth     <= tf.coll ? tf.depth : '0;
      shift0_x  <= live ? sat32(s0[0], tf.neg[0]) : '0;
      shift0_y  <= live ? sat32(s0[1], tf.neg[1]) : '0;
      shift0_z  <= live ? sat32(s0[2], tf.neg[2]) : '0;
      shift1_x  <= live ? sat32(s1[0], !tf.neg[0]) : '0;
      shift1_y  <= live ? sat32(s1[1], !tf.neg[1]) : '0;
      shift1_z  <= live ? sat32(s1[2], !tf.neg[2]) : '0;
      normal_x  <= live ? nv[0][17:0] : '0;
      normal_y  <= live ? nv[1][17:0] : '0;
      normal_z  <= live ? nv[2][17:0] : '0;
    end
  end

  always_comb begin
    live = tf.coll && !tf.zd;
    for (int i = 0; i < 3; i++) begin
      s0[i] = pf0[i] >> FRAC_BITS;
      s1[i] = pf1[i] >> FRAC_BITS;
      nv[i] = tf.neg[i] ? 32'(0) - nf[i] : nf[i];
    end
  end

endmodule

// ===== hw/rtl/scc_front.sv =====
// front stages: center differences, squares and the squared distance
// depends on scc_pkg
module scc_front import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] pos0_x,
  input  logic signed [31:0] pos0_y,
  input  logic signed [31:0] pos0_z,
  input  logic signed [31:0] pos1_x,
  input  logic signed [31:0] pos1_y,
  input  logic signed [31:0] pos1_z,
  input  logic [30:0]        radius0,
  input  logic [30:0]        radius1,
  input  logic [23:0]        weight0,
  input  logic [23:0]        weight1,
  output side_t              side,
  output logic [63:0]        sum
);

  side_t       sa, sb, sb_o;
  logic [63:0] sq [3];
  logic [32:0] dxa, dya, dza;
  logic [65:0] tot;

  always_comb begin
    dxa = (pos0_x < pos1_x) ? 33'(signed'(pos1_x)) - 33'(signed'(pos0_x))
                            : 33'(signed'(pos0_x)) - 33'(signed'(pos1_x));
    dya = (pos0_y < pos1_y) ? 33'(signed'(pos1_y)) - 33'(signed'(pos0_y))
                            : 33'(signed'(pos0_y)) - 33'(signed'(pos1_y));
    dza = (pos0_z < pos1_z) ? 33'(signed'(pos1_z)) - 33'(signed'(pos0_z))
                            : 33'(signed'(pos0_z)) - 33'(signed'(pos1_z));
  end

  // square sum beyond 64 bits marks a pair too far apart to collide
  always_comb begin
    tot      = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
    sb_o     = sb;
    sb_o.ovf = tot[65:64] != 2'b00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid   <= 1'b0;
      sb.valid   <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      sa.valid <= in_valid;
      sa.neg   <= {pos0_z < pos1_z, pos0_y < pos1_y, pos0_x < pos1_x};
      sa.mag_x <= dxa[31:0];
      sa.mag_y <= dya[31:0];
      sa.mag_z <= dza[31:0];
      sa.rs    <= 32'(radius0) + 32'(radius1);
      sa.w0    <= weight0;
      sa.w1    <= weight1;
      sa.ws    <= 25'(weight0) + 25'(weight1);
      sa.ovf   <= 1'b0;
      sb       <= sa;
      sq[0]    <= sa.mag_x * sa.mag_x;
      sq[1]    <= sa.mag_y * sa.mag_y;
      sq[2]    <= sa.mag_z * sa.mag_z;
      side     <= sb_o;
      sum      <= tot[63:0];
    end
  end

endmodule

// ===== hw/rtl/scc_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on scc_pkg
module scc_sqrt import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  side_t       side_in,
  input  logic [63:0] num_in,
  output side_t       side_out,
  output logic [31:0] root
);

  side_t       side [SQRT_STEPS+1];
  logic [63:0] num  [SQRT_STEPS+1];
  logic [63:0] res  [SQRT_STEPS+1];
  logic [63:0] bitv [SQRT_STEPS];
  logic [63:0] trial [SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      bitv[k]  = 64'(1) << (62 - 2 * k);
      trial[k] = res[k] + bitv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQRT_STEPS; k++) side[k].valid <= 1'b0;
    end else if (en) begin
      side[0] <= side_in;
      num[0]  <= num_in;
      res[0]  <= '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        side[k+1] <= side[k];
        if (num[k] >= trial[k]) begin
          num[k+1] <= num[k] - trial[k];
          res[k+1] <= (res[k] >> 1) + bitv[k];
        end else begin
          num[k+1] <= num[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign side_out = side[SQRT_STEPS];
  assign root     = res[SQRT_STEPS][31:0];

endmodule

// ===== hw/rtl/scc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on scc_pkg
module scc_div import scc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic [31:0]      quo
);

  logic [31:0] rem  [DIV_STEPS+1];
  logic [31:0] low  [DIV_STEPS+1];
  logic [31:0] dv   [DIV_STEPS+1];
  logic [31:0] q    [DIV_STEPS+1];
  logic [32:0] t    [DIV_STEPS];
  logic        ge   [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      t[k]  = {rem[k], low[k][31]};
      ge[k] = t[k] >= {1'b0, dv[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 32'(num[NUM_W-1:32]);
      low[0] <= num[31:0];
      dv[0]  <= den;
      q[0]   <= '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem[k+1] <= ge[k] ? 32'(t[k] - {1'b0, dv[k]}) : t[k][31:0];
        low[k+1] <= low[k] << 1;
        dv[k+1]  <= dv[k];
        q[k+1]   <= {q[k][30:0], ge[k]};
      end
    end
  end

  assign quo = q[DIV_STEPS];

endmodule

// ===== verif/sphere_collision_constraint_top_tb.sv =====
// testbench for the sphere collision constraint pipeline: directed table, then random pairs
// checks every response against a typed expectation or a built-in fixed point predictor; depends on scc_pkg and the rtl
`timescale 1ns / 100ps

module sphere_collision_constraint_top_tb import scc_pkg::*; ();

  localparam int LATENCY = 72;
  localparam int RANDOM_PAIRS = 700;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] p0x, p0y, p0z, p1x, p1y, p1z;
    logic [30:0] r0, r1;
    logic [23:0] w0, w1;
  } pair_t;

  typedef struct {
    logic collided;
    logic signed [31:0] s0x, s0y, s0z, s1x, s1y, s1z;
    logic signed [17:0] nx, ny, nz;
    logic [31:0] depth;
  } contact_t;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  logic signed [31:0] pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z;
  logic [30:0] radius0, radius1;
  logic [23:0] weight0, weight1;
  logic collided;
  logic signed [31:0] shift0_x, shift0_y, shift0_z, shift1_x, shift1_y, shift1_z;
  logic signed [17:0] normal_x, normal_y, normal_z;
  logic [31:0] depth;

  contact_t contact_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_rsp = 0;
  bit gaps_on = 1;

  sphere_collision_constraint_top DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] root_floor(logic [63:0] num);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > num) bitv >>= 2;
    while (bitv != 0) begin
      if (num >= res + bitv) begin
        num -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(logic [63:0] mag, bit neg);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic contact_t resolve_contact(pair_t p);
    contact_t c;
    logic signed [63:0] dv[3];
    logic [63:0] mag[3], sum, sq, span, dep, sh0, sh1, nm, ws, rs, s0, s1;
    logic [31:0] sv0[3], sv1[3];
    logic [17:0] nv[3];
    bit neg;
    c = '{default: 0};
    dv[0] = 64'(p.p0x) - 64'(p.p1x);
    dv[1] = 64'(p.p0y) - 64'(p.p1y);
    dv[2] = 64'(p.p0z) - 64'(p.p1z);
    for (int i = 0; i < 3; i++) mag[i] = dv[i] < 0 ? -dv[i] : dv[i];
    rs = 64'(p.r0) + 64'(p.r1);
    ws = 64'(p.w0) + 64'(p.w1);
    if (ws == 0) return c;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      sq = mag[i] * mag[i];
      if (sum + sq < sum) return c;
      sum += sq;
    end
    span = root_floor(sum);
    if (!(span + EPS < rs)) return c;
    dep = rs - span;
    sh0 = dep * p.w0 / ws;
    sh1 = dep * p.w1 / ws;
    c.collided = 1;
    c.depth = dep[31:0];
    if (span == 0) return c;
    for (int i = 0; i < 3; i++) begin
      nm = (mag[i] << FRAC_BITS) / span;
      neg = dv[i] < 0;
      s0 = (sh0 * nm) >> FRAC_BITS;
      s1 = (sh1 * nm) >> FRAC_BITS;
      nv[i] = neg ? 18'(-nm) : nm[17:0];
      sv0[i] = clamp32(s0, neg);
      sv1[i] = clamp32(s1, !neg && s1 != 0);
    end
    c.nx = nv[0]; c.ny = nv[1]; c.nz = nv[2];
    c.s0x = sv0[0]; c.s0y = sv0[1]; c.s0z = sv0[2];
    c.s1x = sv1[0]; c.s1y = sv1[1]; c.s1z = sv1[2];
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic pause_gap();
    int n;
    if (!gaps_on) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) req_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // drive one transaction and hold it until accepted
  task automatic send_pair(pair_t p, bit typed, contact_t want);
    pause_gap();
    req_valid <= 1;
    pos0_x <= p.p0x; pos0_y <= p.p0y; pos0_z <= p.p0z;
    pos1_x <= p.p1x; pos1_y <= p.p1y; pos1_z <= p.p1z;
    radius0 <= p.r0; radius1 <= p.r1; weight0 <= p.w0; weight1 <= p.w1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    contact_q.push_back(typed ? want : resolve_contact(p));
  endtask

  always @(posedge clk) begin
    contact_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (contact_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        w = contact_q.pop_front();
        if (collided !== w.collided) report_mismatch("collided", collided, w.collided);
        if (shift0_x !== w.s0x) report_mismatch("shift0_x", shift0_x, w.s0x);
        if (shift0_y !== w.s0y) report_mismatch("shift0_y", shift0_y, w.s0y);
        if (shift0_z !== w.s0z) report_mismatch("shift0_z", shift0_z, w.s0z);
        if (shift1_x !== w.s1x) report_mismatch("shift1_x", shift1_x, w.s1x);
        if (shift1_y !== w.s1y) report_mismatch("shift1_y", shift1_y, w.s1y);
        if (shift1_z !== w.s1z) report_mismatch("shift1_z", shift1_z, w.s1z);
        if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
        if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
        if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
        if (depth !== w.depth) report_mismatch("depth", depth, w.depth);
      end
    end
  end

  // receiver stall with occasional long hold
  always @(posedge clk) begin
    if (rst || !gaps_on) rsp_stall <= 0;
    else if (hold_rsp) rsp_stall <= 1;
    else if ($urandom_range(0, 39) == 0) rsp_stall <= 1;
    else if (rsp_stall && $urandom_range(0, 3) != 0) rsp_stall <= 1;
    else rsp_stall <= ($urandom_range(0, 5) == 0);
  end

  initial begin
    wait (!rst);
    repeat (150) @(posedge clk);
    hold_rsp <= 1;
    repeat (200) @(posedge clk);
    hold_rsp <= 0;
  end

  function automatic pair_t random_pair();
    pair_t p;
    int k;
    k = $urandom_range(0, 9);
    p.p0x = $urandom; p.p0y = $urandom; p.p0z = $urandom;
    p.p1x = $urandom; p.p1y = $urandom; p.p1z = $urandom;
    p.r0 = 31'($urandom); p.r1 = 31'($urandom);
    p.w0 = 24'($urandom); p.w1 = 24'($urandom);
    if (k < 7) begin
      // nearby pairs so that most of them overlap
      p.p0x = $signed($urandom) >>> $urandom_range(8, 28);
      p.p0y = $signed($urandom) >>> $urandom_range(8, 28);
      p.p0z = $signed($urandom) >>> $urandom_range(8, 28);
      p.p1x = p.p0x + ($signed($urandom) >>> $urandom_range(6, 26));
      p.p1y = p.p0y + ($signed($urandom) >>> $urandom_range(6, 26));
      p.p1z = p.p0z + ($signed($urandom) >>> $urandom_range(6, 26));
      p.r0 = 31'($urandom >> $urandom_range(1, 24));
      p.r1 = 31'($urandom >> $urandom_range(1, 24));
    end
    if (k == 7) p.w0 = 0;
    if (k == 8) p.w1 = 0;
    return p;
  endfunction

  initial begin
    pair_t tbl[$];
    bit typed[$];
    contact_t want[$];
    pair_t p;
    contact_t z;
    z = '{default: 0};
    rst = 1;
    req_valid = 0;
    {pos0_x, pos0_y, pos0_z, pos1_x, pos1_y, pos1_z} = '0;
    {radius0, radius1, weight0, weight1} = '0;
    // both weights zero
    tbl.push_back('{0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0});
    typed.push_back(1); want.push_back(z);
    // coincident centres
    tbl.push_back('{5, 5, 5, 5, 5, 5, 31'h10000, 31'h10000, 24'h10000, 24'h10000});
    typed.push_back(1);
    want.push_back('{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h20000});
    // far apart, square sum overflows
    tbl.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFFFFFF, 24'hFFFFFF});
    typed.push_back(1); want.push_back(z);
    // touching within eps and no overlap
    tbl.push_back('{32'h20000, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 24'h10000, 24'h10000});
    typed.push_back(1); want.push_back(z);
    // overlap along each axis, with both signs among them, weights at extremes
    tbl.push_back('{32'h10000, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 24'h10000, 24'h10000});
    tbl.push_back('{0, -32'sh10000, 0, 0, 0, 0, 31'h10000, 31'h10000, 24'hFFFFFF, 0});
    tbl.push_back('{0, 0, 32'h8000, 0, 0, 0, 31'h10000, 31'h8000, 0, 24'hFFFFFF});
    tbl.push_back('{0, 0, -32'sh1, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'h1, 24'hFFFFFF});
    // saturating shifts
    tbl.push_back('{1, 1, 1, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFFFFFF, 24'h1});
    tbl.push_back('{-1, -1, -1, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'h1, 24'hFFFFFF});
    tbl.push_back('{32'h7FFF_FFFF, 0, 0, 32'h7FFF_0000, 0, 0,
                    31'h7FFF_FFFF, 0, 24'h800000, 24'h800000});
    tbl.push_back('{32'h8000_0000, 32'h8000_0000, 0, 32'h8000_1000, 32'h8000_1000, 0,
                    31'h0, 31'h7FFF_FFFF, 24'hAAAAAA, 24'h555555});
    for (int i = typed.size(); i < tbl.size(); i++) begin
      typed.push_back(0); want.push_back(z);
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < tbl.size(); i++) send_pair(tbl[i], typed[i], want[i]);
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 2) begin
        // drain the pipeline, then push back to back with no gaps
        req_valid <= 0;
        while (contact_q.size() != 0) @(posedge clk);
        gaps_on = 0;
      end
      if (i == RANDOM_PAIRS / 2 + 80) gaps_on = 1;
      p = random_pair();
      send_pair(p, 0, z);
    end
    req_valid <= 0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sphere_collision_constraint_top.f =====
hw/rtl/scc_pkg.sv
hw/rtl/scc_front.sv
hw/rtl/scc_sqrt.sv
hw/rtl/scc_div.sv
hw/rtl/sphere_collision_constraint_top.sv
verif/sphere_collision_constraint_top_tb.sv
